[hw/rtl/freq_limit_request_aggregator_top_defines.svh]
// Assertion macros shared by the frequency limit request aggregator.
`ifndef FREQ_LIMIT_REQUEST_AGGREGATOR_TOP_DEFINES_SVH
`define FREQ_LIMIT_REQUEST_AGGREGATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define FLRA_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FLRA_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define FLRA_ASSERT(lbl, clk, rst_n, prop, msg)
`define FLRA_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

[hw/rtl/flra_pkg.sv]
`timescale 1ns / 1ps

package flra_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	localparam int ARGC_W     = 2;
	localparam int ID_W       = 22;
	localparam int FREQ_W     = 24;
	localparam int CFG_IDX_W  = 2;
	localparam int IN_DATA_W  = 48;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 24;
	localparam int OUT_USER_W = 4;

	localparam logic [FREQ_W-1:0] HW_MAX_RESET = 24'd1200000;
	localparam logic [FREQ_W-1:0] HW_MIN_RESET = 24'd100000;

	localparam logic [CFG_IDX_W-1:0] REG_HW_MAX = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HW_MIN = 2'd1;

	localparam logic [ARGC_W-1:0] ARGS_SET     = 2'd2;
	localparam logic [ARGC_W-1:0] ARGS_RELEASE = 2'd1;

	typedef enum logic [1:0] {
		ACT_SET_CEIL  = 2'd0,
		ACT_SET_FLOOR = 2'd1,
		ACT_REL_CEIL  = 2'd2,
		ACT_REL_FLOOR = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_ARGS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef struct packed {
		logic load;
		logic step;
		logic commit;
	} flra_cmd_t;

	typedef struct packed {
		logic arg_err;
		logic scan_last;
		logic out_free;
	} flra_stat_t;

endpackage

[hw/rtl/flra_ctrl.sv]
`timescale 1ns / 1ps
`include "freq_limit_request_aggregator_top_defines.svh"

module flra_ctrl import flra_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	output flra_cmd_t  cmd,
	input  flra_stat_t stat
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

	state_t state_q;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		cmd.load   = s_tready && s_tvalid;
		cmd.step   = (state_q == S_SCAN) && !stat.arg_err;
		cmd.commit = (state_q == S_DONE) && stat.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) state_q <= S_SCAN;
				end
				S_SCAN: begin
					// A malformed request skips the table altogether.
					if (stat.arg_err || stat.scan_last) state_q <= S_DONE;
				end
				S_DONE: begin
					if (stat.out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`FLRA_ASSERT(a_load_starts_scan, clk, arst_n, cmd.load |=> (state_q == S_SCAN), "accepted request did not start a scan")
	`FLRA_ASSERT(a_last_step_done, clk, arst_n, (cmd.step && stat.scan_last) |=> (state_q == S_DONE), "scan ran past the last entry")
	`FLRA_NEVER(a_commit_blocked, clk, arst_n, cmd.commit && !stat.out_free, "result committed over an untaken result")

endmodule

[hw/rtl/flra_dp.sv]
`timescale 1ns / 1ps
`include "freq_limit_request_aggregator_top_defines.svh"

module flra_dp import flra_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  flra_cmd_t             cmd,
	output flra_stat_t            stat,
	input  logic [IN_USER_W-1:0]  s_tuser,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [FREQ_W-1:0]     cfg_data,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic [OUT_USER_W-1:0] m_tuser
);

	// Request held for the duration of its scan.
	action_t             act_q;
	logic [ARGC_W-1:0]   argc_q;
	logic [ID_W-1:0]     rid_q;
	logic [FREQ_W-1:0]   rfreq_q;

	// Scan state.
	logic [IDX_W-1:0]    idx_q;
	logic [FREQ_W-1:0]   acc_q;
	logic                acc_any_q;
	logic                match_found_q;
	logic                free_found_q;
	logic [IDX_W-1:0]    match_idx_q;
	logic [IDX_W-1:0]    free_idx_q;

	// Request tables, index 0 ceiling and 1 floor.
	logic [1:0][TABLE_DEPTH-1:0] valid_q;
	logic [ID_W-1:0]             id_q   [2][TABLE_DEPTH];
	logic [FREQ_W-1:0]           freq_q [2][TABLE_DEPTH];

	logic [FREQ_W-1:0]   hw_max_q;
	logic [FREQ_W-1:0]   hw_min_q;

	logic                m_tvalid_q;
	logic [FREQ_W-1:0]   out_khz_q;
	logic                out_target_q;
	logic                out_written_q;
	status_t             out_status_q;

	logic                which;
	logic                is_set;
	logic                arg_err;
	logic                e_valid;
	logic [FREQ_W-1:0]   e_freq;
	logic                e_hit;
	logic                take_match;
	logic                clear_hit;
	logic                e_include;
	logic                e_better;
	logic                new_better;
	logic                full;
	logic [IDX_W-1:0]    slot;
	logic                do_write;
	status_t             res_status;
	logic [FREQ_W-1:0]   res_khz;

	always_comb begin
		unique case (act_q)
			ACT_SET_CEIL: begin
				which  = 1'b0;
				is_set = 1'b1;
			end
			ACT_SET_FLOOR: begin
				which  = 1'b1;
				is_set = 1'b1;
			end
			ACT_REL_CEIL: begin
				which  = 1'b0;
				is_set = 1'b0;
			end
			ACT_REL_FLOOR: begin
				which  = 1'b1;
				is_set = 1'b0;
			end
			default: begin
				which  = 1'b0;
				is_set = 1'b0;
			end
		endcase
	end

	assign arg_err = is_set ? (argc_q < ARGS_SET) : (argc_q < ARGS_RELEASE);

	// One table entry is examined per scan step.
	assign e_valid    = valid_q[which][idx_q];
	assign e_freq     = freq_q[which][idx_q];
	assign e_hit      = e_valid && (id_q[which][idx_q] == rid_q);
	assign take_match = is_set && e_hit && !match_found_q;
	assign clear_hit  = !is_set && e_hit;
	assign e_include  = e_valid && !take_match && !clear_hit;
	assign e_better   = which ? (e_freq > acc_q) : (e_freq < acc_q);
	assign new_better = which ? (rfreq_q > acc_q) : (rfreq_q < acc_q);

	assign full     = is_set && !match_found_q && !free_found_q;
	assign slot     = match_found_q ? match_idx_q : free_idx_q;
	assign do_write = cmd.commit && is_set && !arg_err && !full;

	always_comb begin
		if (arg_err) begin
			res_status = ST_ARGS;
			res_khz    = '0;
		end else if (full) begin
			res_status = ST_FULL;
			res_khz    = '0;
		end else if (is_set) begin
			// The entry being written joins the aggregate of the others.
			res_status = ST_OK;
			res_khz    = (acc_any_q && !new_better) ? acc_q : rfreq_q;
		end else begin
			res_status = ST_OK;
			res_khz    = acc_any_q ? acc_q : (which ? hw_min_q : hw_max_q);
		end
	end

	always_comb begin
		stat.arg_err   = arg_err;
		stat.scan_last = (idx_q == IDX_W'(TABLE_DEPTH - 1));
		stat.out_free  = !m_tvalid_q || m_tready;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q   <= action_t'(s_tuser);
			argc_q  <= s_tdata[ARGC_W-1:0];
			rid_q   <= s_tdata[ARGC_W +: ID_W];
			rfreq_q <= s_tdata[ARGC_W + ID_W +: FREQ_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q         <= '0;
			acc_q         <= '0;
			acc_any_q     <= 1'b0;
			match_found_q <= 1'b0;
			free_found_q  <= 1'b0;
			match_idx_q   <= '0;
			free_idx_q    <= '0;
		end else if (cmd.load) begin
			idx_q         <= '0;
			acc_any_q     <= 1'b0;
			match_found_q <= 1'b0;
			free_found_q  <= 1'b0;
		end else if (cmd.step) begin
			idx_q <= idx_q + IDX_W'(1);
			if (take_match) begin
				match_found_q <= 1'b1;
				match_idx_q   <= idx_q;
			end
			if (!e_valid && !free_found_q) begin
				free_found_q <= 1'b1;
				free_idx_q   <= idx_q;
			end
			if (e_include && (!acc_any_q || e_better)) begin
				acc_q     <= e_freq;
				acc_any_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (cmd.step && clear_hit) valid_q[which][idx_q] <= 1'b0;
			if (do_write) valid_q[which][slot] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_write) begin
			id_q[which][slot]   <= rid_q;
			freq_q[which][slot] <= rfreq_q;
		end
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_max_q <= HW_MAX_RESET;
			hw_min_q <= HW_MIN_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_HW_MAX: hw_max_q <= cfg_data;
				REG_HW_MIN: hw_min_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.commit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_khz_q     <= res_khz;
			out_target_q  <= which;
			out_written_q <= (res_status == ST_OK);
			out_status_q  <= res_status;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_khz_q;
	assign m_tuser  = {out_status_q, out_written_q, out_target_q};

	`FLRA_NEVER(a_write_over_live, clk, arst_n, do_write && !match_found_q && valid_q[which][slot], "new request overwrote a live entry")

endmodule

[hw/rtl/freq_limit_request_aggregator_top.sv]
`timescale 1ns / 1ps
// Frequency limit request aggregator.
// Requests arrive on the s_ stream: s_tuser carries the action (set or release
// of the ceiling or the floor), s_tdata the argument count, requester id and
// frequency. Each request yields exactly one result on the m_ stream: the new
// minimum of the ceiling table or maximum of the floor table in m_tdata, the
// hardware limit when that table is empty, or zero on an error status, with
// table, written flag and status in m_tuser.
// Each request walks its 16-entry table one entry per cycle, then the result is
// registered in the output register; a new request can be taken in the cycle
// after the result is registered, not before. Malformed requests skip the walk.
// The hardware limits are written through the cfg_ port (index 0 maximum,
// index 1 minimum); the user must write them only while no request is in
// flight, as the block does not enforce it; cfg_ready is always high.
// Reset empties both tables and restores the default limits at once.
// A result waits in the output register while m_tready is low; the next
// request is still taken and scanned, then holds until the output frees up.

module freq_limit_request_aggregator_top import flra_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // arg_count, requester_id, freq_khz
	input  logic [IN_USER_W-1:0]  s_tuser,   // action
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // limit_khz
	output logic [OUT_USER_W-1:0] m_tuser,   // target_limit, limit_written, status
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [FREQ_W-1:0]     cfg_data
);

	flra_cmd_t  cmd;
	flra_stat_t stat;

	flra_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

	flra_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule
